/* hdl/cfb_pkg.sv */
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the CRC byte update for the CRC frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    // Item kinds carried in req_type
    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Frame bytes
    localparam logic [7:0] FRAME_DELIM = 8'hC0;
    localparam logic [7:0] FRAME_LEAD  = 8'h03;
    localparam logic [7:0] FRAME_PAD   = 8'h00;

    // Reset value of the generator polynomial
    localparam logic [15:0] CRC_POLY_RESET = 16'h1021;

    // Step counter: body lengths and trailer length
    localparam int unsigned STEP_W      = 4;
    localparam logic [STEP_W-1:0] HDR_LEN     = 4'd8;
    localparam logic [STEP_W-1:0] PAY_LEN     = 4'd1;
    localparam logic [STEP_W-1:0] TRAILER_LEN = 4'd3;

    // Input item
    typedef struct packed {
        logic        req_type;
        logic [31:0] addr;
        logic [7:0]  cmd_code;
        logic [7:0]  data_byte;
        logic        frame_end;
    } req_item_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_last;
        logic       run_last;
    } tx_item_t;

    // Direct MSB-first CRC over one byte. With a zero start value this equals
    // the augmented CRC after two trailing zero bytes.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ data[k];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/cfb_in_stage.sv */
// ----------------------------------------------------------------------------
// cfb_in_stage
// Input register: holds the item being serialized until its last byte leaves.
// ----------------------------------------------------------------------------
module cfb_in_stage
    import cfb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req_data,
    input  logic      item_done,
    output logic      item_valid,
    output req_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    req_item_t item_reg;
    logic      take;

    // Accept a new transfer when empty or when the held item finishes now
    assign req_ready = !valid_reg || item_done;
    assign take      = req_valid && req_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (item_done)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= req_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/cfb_serializer.sv */
// ----------------------------------------------------------------------------
// cfb_serializer
// Step sequencer: picks the frame byte for each step and keeps the running CRC.
// ----------------------------------------------------------------------------
module cfb_serializer
    import cfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] crc_poly,
    input  logic        item_valid,
    input  req_item_t   item,
    input  logic        load_ok,
    output logic        emit,
    output tx_item_t    result,
    output logic        item_done
);

    // Header byte positions
    localparam logic [2:0] HDR_DELIM = 3'd0;
    localparam logic [2:0] HDR_LEAD  = 3'd1;
    localparam logic [2:0] HDR_A0    = 3'd2;
    localparam logic [2:0] HDR_A1    = 3'd3;
    localparam logic [2:0] HDR_A2    = 3'd4;
    localparam logic [2:0] HDR_A3    = 3'd5;
    localparam logic [2:0] HDR_PAD   = 3'd6;
    localparam logic [2:0] HDR_CMD   = 3'd7;

    // Trailer byte positions
    localparam logic [STEP_W-1:0] TRL_CRC_HI = 4'd0;
    localparam logic [STEP_W-1:0] TRL_CRC_LO = 4'd1;
    localparam logic [STEP_W-1:0] TRL_DELIM  = 4'd2;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [15:0]       crc_reg;
    logic [15:0]       crc_next;
    logic              in_frame_reg;
    logic              in_frame_next;

    logic [STEP_W-1:0] body_len;
    logic [STEP_W-1:0] trl_idx;
    logic              is_header;
    logic              is_trailer;
    logic              last_step;
    logic              drop;
    logic              covered;
    logic              closing;
    logic [7:0]        sel_byte;

    // Decode the current step
    always_comb
    begin
        is_header  = (item.req_type == REQ_HEADER);
        body_len   = is_header ? HDR_LEN : PAY_LEN;
        is_trailer = (step_reg >= body_len);
        trl_idx    = step_reg - body_len;
        last_step  = item.frame_end ? (step_reg == body_len + TRAILER_LEN - 4'd1)
                                    : (step_reg == body_len - 4'd1);
        drop       = item_valid && !is_header && !in_frame_reg;
        emit       = item_valid && !drop && load_ok;
        item_done  = drop || (emit && last_step);
        covered    = !is_trailer && !(is_header && step_reg[2:0] == HDR_DELIM);
        closing    = is_trailer && (trl_idx == TRL_DELIM);
    end

    // Select the byte for this step
    always_comb
    begin
        sel_byte = FRAME_DELIM;
        if (is_trailer)
        begin
            unique case (trl_idx)
                TRL_CRC_HI: sel_byte = crc_reg[15:8];
                TRL_CRC_LO: sel_byte = crc_reg[7:0];
                default:    sel_byte = FRAME_DELIM;
            endcase
        end
        else if (is_header)
        begin
            unique case (step_reg[2:0])
                HDR_DELIM: sel_byte = FRAME_DELIM;
                HDR_LEAD:  sel_byte = FRAME_LEAD;
                HDR_A0:    sel_byte = item.addr[7:0];
                HDR_A1:    sel_byte = item.addr[15:8];
                HDR_A2:    sel_byte = item.addr[23:16];
                HDR_A3:    sel_byte = item.addr[31:24];
                HDR_PAD:   sel_byte = FRAME_PAD;
                HDR_CMD:   sel_byte = item.cmd_code;
            endcase
        end
        else
        begin
            sel_byte = item.data_byte;
        end
    end

    assign result.out_byte   = sel_byte;
    assign result.frame_last = closing;
    assign result.run_last   = last_step;

    // Advance the step, CRC and frame flag on each emitted byte
    always_comb
    begin
        step_next     = step_reg;
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (emit)
        begin
            step_next = last_step ? '0 : step_reg + 4'd1;
            if (is_header && !is_trailer && step_reg[2:0] == HDR_DELIM)
            begin
                crc_next      = '0;
                in_frame_next = 1'b1;
            end
            else if (covered)
            begin
                crc_next = crc_update(crc_reg, sel_byte, crc_poly);
            end
            else if (closing)
            begin
                crc_next      = '0;
                in_frame_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= '0;
            crc_reg      <= '0;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            step_reg     <= step_next;
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

/* hdl/cfb_out_stage.sv */
// ----------------------------------------------------------------------------
// cfb_out_stage
// Result register: holds one frame byte until the sink takes the transfer.
// ----------------------------------------------------------------------------
module cfb_out_stage
    import cfb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     emit,
    input  tx_item_t result,
    output logic     load_ok,
    output logic     tx_valid,
    input  logic     tx_ready,
    output tx_item_t tx_data
);

    logic     valid_reg;
    logic     valid_next;
    tx_item_t data_reg;

    // Load when empty or when the held byte leaves this cycle
    assign load_ok = !valid_reg || tx_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (emit)
        begin
            valid_next = 1'b1;
        end
        else if (tx_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= result;
        end
    end

    assign tx_valid = valid_reg;
    assign tx_data  = data_reg;

endmodule

/* hdl/crc_frame_builder.sv */
// ----------------------------------------------------------------------------
// crc_frame_builder
// Serializes command frames with a CRC-16 trailer, one byte per transfer.
// ----------------------------------------------------------------------------
// Path: an item waits in the input register and its first byte is loaded into
//   the output register once that register can take it.
// Throughput: one output byte per cycle while tx_ready is high. A payload item
//   gives one byte, a header eight, three more for a closing trailer; ignored
//   payloads give none. The single byte-wide output register sets the rate.
// Reset: asynchronous, clears both stages, the CRC, the frame flag and sets
//   the polynomial to 0x1021.
module crc_frame_builder
    import cfb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_item_t   req_data,
    output logic        tx_valid,
    input  logic        tx_ready,
    output tx_item_t    tx_data
);

    logic [15:0] poly_reg;
    logic        item_valid;
    req_item_t   item;
    logic        item_done;
    logic        load_ok;
    logic        emit;
    tx_item_t    result;

    // Polynomial register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            poly_reg <= cfg_data;
        end
    end

    cfb_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .item_done  (item_done),
        .item_valid (item_valid),
        .item       (item)
    );

    cfb_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .crc_poly   (poly_reg),
        .item_valid (item_valid),
        .item       (item),
        .load_ok    (load_ok),
        .emit       (emit),
        .result     (result),
        .item_done  (item_done)
    );

    cfb_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .result   (result),
        .load_ok  (load_ok),
        .tx_valid (tx_valid),
        .tx_ready (tx_ready),
        .tx_data  (tx_data)
    );

endmodule

/* tb/crc_frame_builder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_frame_builder_tb
// Self-checking bench for the CRC frame builder. A scoreboard predicts every
// output byte of each accepted request: header fields, payload pass-through
// and the augmented CRC-16 trailer. It checks the bytes in order against the
// output channel. Phases step through several generator polynomials and
// mixes of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module crc_frame_builder_tb;
    import cfb_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_MAX    = 10;
    localparam int unsigned PHASE_ITEMS   = 60;
    localparam int unsigned NUM_PHASES    = 5;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts frame bytes, checks each output transfer in order
    // ------------------------------------------------------------------------
    class frame_checker;
        logic [15:0] poly;
        logic [15:0] crc;
        bit          frame_open;
        tx_item_t    expected_bytes[$];
        int unsigned failures;
        int unsigned reported;

        function new();
            poly       = CRC_POLY_RESET;
            crc        = '0;
            frame_open = 1'b0;
            failures   = 0;
            reported   = 0;
        endfunction

        // Shift one byte, MSB first, into the augmented CRC
        function logic [15:0] shift_byte(logic [15:0] c, logic [7:0] b);
            logic top;
            for (int k = 7; k >= 0; k--)
            begin
                top = c[15];
                c   = {c[14:0], b[k]};
                if (top)
                begin
                    c = c ^ poly;
                end
            end
            return c;
        endfunction

        function void put(logic [7:0] b, logic last, bit covered);
            tx_item_t item;
            item.out_byte   = b;
            item.frame_last = last;
            item.run_last   = 1'b0;
            expected_bytes.push_back(item);
            if (covered)
            begin
                crc = shift_byte(crc, b);
            end
        endfunction

        // Note an accepted request; return 1 if it produces output bytes
        function bit note_request(req_item_t r);
            tx_item_t    item;
            logic [15:0] trailer;
            if (r.req_type == REQ_HEADER)
            begin
                crc        = '0;
                frame_open = 1'b1;
                put(FRAME_DELIM, 1'b0, 1'b0);
                put(FRAME_LEAD, 1'b0, 1'b1);
                for (int b = 0; b < 4; b++)
                begin
                    put(r.addr[8*b +: 8], 1'b0, 1'b1);
                end
                put(FRAME_PAD, 1'b0, 1'b1);
                put(r.cmd_code, 1'b0, 1'b1);
            end
            else
            begin
                // Drop payload outside a frame
                if (!frame_open)
                begin
                    return 1'b0;
                end
                put(r.data_byte, 1'b0, 1'b1);
            end
            // Close with two augmentation zeros folded into the trailer
            if (r.frame_end)
            begin
                trailer = shift_byte(shift_byte(crc, 8'h00), 8'h00);
                put(trailer[15:8], 1'b0, 1'b0);
                put(trailer[7:0], 1'b0, 1'b0);
                put(FRAME_DELIM, 1'b1, 1'b0);
                crc        = '0;
                frame_open = 1'b0;
            end
            item = expected_bytes.pop_back();
            item.run_last = 1'b1;
            expected_bytes.push_back(item);
            return 1'b1;
        endfunction

        function void check_byte(tx_item_t got);
            tx_item_t want;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display("unexpected output: byte %02h last %b run %b",
                             got.out_byte, got.frame_last, got.run_last);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.frame_last !== want.frame_last ||
                got.run_last !== want.run_last)
            begin
                failures++;
                if (reported < REPORT_MAX)
                begin
                    reported++;
                    $display({"mismatch: expected byte %02h last %b run %b, ",
                              "got byte %02h last %b run %b"},
                             want.out_byte, want.frame_last, want.run_last,
                             got.out_byte, got.frame_last, got.run_last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_item_t   req_data  = '0;
    logic        tx_valid;
    logic        tx_ready  = 1'b0;
    tx_item_t    tx_data;

    frame_checker sb;
    int unsigned  cycle_count    = 0;
    int unsigned  fed_items      = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;

    crc_frame_builder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .tx_valid  (tx_valid),
        .tx_ready  (tx_ready),
        .tx_data   (tx_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("crc_frame_builder verification failed");
        $finish;
    end

    // Randomize receiver back-pressure
    always @(negedge clk)
    begin
        tx_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && tx_valid && tx_ready)
        begin
            sb.check_byte(tx_data);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic req_item_t make_header(logic [31:0] a, logic [7:0] c, logic fe);
        req_item_t r;
        r.req_type  = REQ_HEADER;
        r.addr      = a;
        r.cmd_code  = c;
        r.data_byte = 8'($urandom);
        r.frame_end = fe;
        return r;
    endfunction

    function automatic req_item_t make_payload(logic [7:0] d, logic fe);
        req_item_t r;
        r.req_type  = REQ_PAYLOAD;
        r.addr      = $urandom;
        r.cmd_code  = 8'($urandom);
        r.data_byte = d;
        r.frame_end = fe;
        return r;
    endfunction

    // Drive one request; called and returns at a falling edge
    task automatic send_request(input req_item_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req_data  = r;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        if (sb.note_request(r))
        begin
            fed_items++;
        end
        @(negedge clk);
    endtask

    task automatic send_frame(input int unsigned n, input bit close);
        send_request(make_header($urandom, 8'($urandom), close && n == 0));
        for (int unsigned i = 0; i < n; i++)
        begin
            send_request(make_payload(8'($urandom), close && i == n - 1));
        end
    endtask

    // Hold until every predicted byte is out, then let the pipeline settle
    task automatic drain();
        req_valid = 1'b0;
        while (sb.expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_poly(input logic [15:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.poly = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Mostly closed frames, some abandoned frames and stray payload bytes
    task automatic run_random(input int unsigned quota);
        int unsigned start_count;
        int unsigned pick;
        start_count = fed_items;
        while (fed_items - start_count < quota)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_frame($urandom_range(0, 6), 1'b1);
            end
            else if (pick < 88)
            begin
                send_frame($urandom_range(0, 3), 1'b0);
            end
            else
            begin
                send_request(make_payload(8'($urandom), 1'($urandom)));
            end
        end
        // Close the last frame before the polynomial changes
        send_frame($urandom_range(0, 4), 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] poly_list [NUM_PHASES];
        sb = new();
        poly_list[0] = 16'h0000;
        poly_list[1] = 16'hFFFF;
        poly_list[2] = 16'h8005;
        poly_list[3] = 16'($urandom);
        poly_list[4] = CRC_POLY_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, header-only frame, stray payload, abandoned frame
        send_request(make_header(32'h0000_0000, 8'h00, 1'b1));
        send_request(make_header(32'hFFFF_FFFF, 8'hFF, 1'b0));
        send_request(make_payload(8'h00, 1'b0));
        send_request(make_payload(8'hFF, 1'b0));
        send_request(make_payload(8'h80, 1'b1));
        send_request(make_payload(8'h5A, 1'b0));
        send_request(make_payload(8'hA5, 1'b1));
        send_request(make_header(32'h1234_5678, 8'h5A, 1'b0));
        send_request(make_payload(8'h11, 1'b0));
        send_request(make_header(32'h89AB_CDEF, 8'h01, 1'b0));
        send_request(make_payload(8'h22, 1'b1));
        send_request(make_header(32'h8000_0001, 8'h80, 1'b0));
        send_request(make_payload(8'h01, 1'b1));
        send_request(make_header(32'h5555_AAAA, 8'h7F, 1'b1));
        drain();

        // Random phases: new polynomial each time, idle mix from four settings in turn
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_poly(poly_list[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 55;
                end
                default:
                begin
                    send_idle_pct  = 26;
                    recv_stall_pct = 26;
                end
            endcase
            run_random(PHASE_ITEMS);
            drain();
        end

        if (sb.failures == 0)
        begin
            $display("crc_frame_builder verification clean");
        end
        else
        begin
            $display("crc_frame_builder verification failed");
        end
        $finish;
    end

endmodule
